>>> design/cde_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and index helpers for the circular deque engine.
// No dependencies; imported by every module of the block.
package cde_pkg;

	localparam int DEPTH     = 16;
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int CAP_W     = 5;
	localparam int DATA_W    = 32;
	localparam int CAP_BOUND = (DEPTH < 16) ? DEPTH : 16;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(CAP_BOUND);

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [IDX_W:0]   cnt_t;

	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_REAR  = 3'd1;
	localparam logic [2:0] OP_POP_FRONT  = 3'd2;
	localparam logic [2:0] OP_POP_REAR   = 3'd3;
	localparam logic [2:0] OP_DISPLAY    = 3'd4;

	localparam logic [1:0] ST_SHOWN   = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_EMPTY   = 2'd2;
	localparam logic [1:0] ST_INVALID = 2'd3;

	typedef struct packed {
		logic exec;     // apply the accepted operation
		logic start;    // load cursor at front, read first slot
		logic advance;  // step cursor, read next slot
		logic show;     // element results on the output
	} cde_cmd_t;

	typedef struct packed {
		logic show_res; // operation ends in a walk of the contents
		logic at_rear;  // cursor sits on the rear slot
	} cde_sts_t;

	// Step forward modulo the live capacity.
	function automatic idx_t idx_next(input idx_t x, input cnt_t cap);
		cnt_t s;
		s = {1'b0, x} + cnt_t'(1);
		return (s == cap) ? '0 : s[IDX_W-1:0];
	endfunction

	// Step backward modulo the live capacity.
	function automatic idx_t idx_prev(input idx_t x, input cnt_t cap);
		cnt_t m;
		m = cap - cnt_t'(1);
		return (x == '0) ? m[IDX_W-1:0] : x - idx_t'(1);
	endfunction

endpackage

>>> design/cde_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the circular deque engine: accept, decide, walk or report.
// Depends on cde_pkg.
module cde_ctrl import cde_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  cde_sts_t sts,
	output cde_cmd_t cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_DECIDE = 2'd1;
	localparam logic [1:0] S_SHOW   = 2'd2;
	localparam logic [1:0] S_STAT   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				state_d = sts.show_res ? S_SHOW : S_STAT;
			end
			S_SHOW: begin
				if (out_ready && sts.at_rear) state_d = S_IDLE;
			end
			S_STAT: begin
				if (out_ready) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = (state_q == S_SHOW) || (state_q == S_STAT);
	assign cmd.exec    = (state_q == S_IDLE) && in_valid;
	assign cmd.start   = (state_q == S_DECIDE) && sts.show_res;
	assign cmd.advance = (state_q == S_SHOW) && out_ready && !sts.at_rear;
	assign cmd.show    = (state_q == S_SHOW);

endmodule

>>> design/cde_datapath.sv
`timescale 1ns / 1ps
// Datapath of the circular deque engine: slot store, end indices, capacity,
// display cursor and result fields. Depends on cde_pkg.
module cde_datapath import cde_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cde_cmd_t                 cmd,
	input  logic [2:0]               operation,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     cfg_wr_en,
	input  logic [CAP_W-1:0]         cfg_wr_data,
	output cde_sts_t                 sts,
	output logic [1:0]               status,
	output logic signed [DATA_W-1:0] element,
	output logic                     last
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic signed [DATA_W-1:0] rd_data_q;

	logic [CAP_W-1:0] cap_q;
	idx_t front_q, rear_q, cursor_q;
	logic empty_q;
	logic show_q;
	logic [1:0] code_q;

	logic [CAP_W-1:0] cap_clamp;
	cnt_t eff_cap;
	logic full;

	idx_t nx_front, nx_rear, wr_addr, rd_addr, cursor_nx;
	logic nx_empty, nx_show, wr_en;
	logic [1:0] nx_code;

	// Clamp capacity into 1 .. CAP_BOUND.
	always_comb begin
		if (cap_q == '0) begin
			cap_clamp = CAP_W'(1);
		end else if (cap_q > CAP_RESET) begin
			cap_clamp = CAP_RESET;
		end else begin
			cap_clamp = cap_q;
		end
	end
	assign eff_cap = cnt_t'(cap_clamp);
	assign full = !empty_q && (idx_next(rear_q, eff_cap) == front_q);

	always_comb begin
		nx_front = front_q;
		nx_rear  = rear_q;
		nx_empty = empty_q;
		nx_show  = 1'b1;
		nx_code  = ST_SHOWN;
		wr_en    = 1'b0;
		wr_addr  = front_q;
		case (operation)
			OP_PUSH_FRONT, OP_PUSH_REAR: begin
				if (full) begin
					nx_show = 1'b0;
					nx_code = ST_FULL;
				end else begin
					wr_en    = 1'b1;
					nx_empty = 1'b0;
					if (empty_q) begin
						nx_front = '0;
						nx_rear  = '0;
					end else if (operation == OP_PUSH_FRONT) begin
						nx_front = idx_prev(front_q, eff_cap);
					end else begin
						nx_rear = idx_next(rear_q, eff_cap);
					end
					wr_addr = (operation == OP_PUSH_FRONT) ? nx_front : nx_rear;
				end
			end
			OP_POP_FRONT, OP_POP_REAR: begin
				if (empty_q) begin
					nx_show = 1'b0;
					nx_code = ST_EMPTY;
				end else if (front_q == rear_q) begin
					// drop the only element
					nx_front = '0;
					nx_rear  = '0;
					nx_empty = 1'b1;
					nx_show  = 1'b0;
					nx_code  = ST_EMPTY;
				end else if (operation == OP_POP_FRONT) begin
					nx_front = idx_next(front_q, eff_cap);
				end else begin
					nx_rear = idx_prev(rear_q, eff_cap);
				end
			end
			OP_DISPLAY: begin
				if (empty_q) begin
					nx_show = 1'b0;
					nx_code = ST_EMPTY;
				end
			end
			default: begin
				nx_show = 1'b0;
				nx_code = ST_INVALID;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			front_q <= '0;
			rear_q  <= '0;
			empty_q <= 1'b1;
		end else if (cfg_wr_en) begin
			cap_q   <= cfg_wr_data;
			front_q <= '0;
			rear_q  <= '0;
			empty_q <= 1'b1;
		end else if (cmd.exec) begin
			front_q <= nx_front;
			rear_q  <= nx_rear;
			empty_q <= nx_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			show_q <= nx_show;
			code_q <= nx_code;
		end
	end

	// Display cursor and single read port.
	assign cursor_nx = idx_next(cursor_q, eff_cap);
	assign rd_addr   = cmd.start ? front_q : cursor_nx;

	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) begin
			mem[wr_addr] <= value;
		end
		if (cmd.start || cmd.advance) begin
			rd_data_q <= mem[rd_addr];
			cursor_q  <= rd_addr;
		end
	end

	assign sts.show_res = show_q;
	assign sts.at_rear  = (cursor_q == rear_q);

	assign status  = cmd.show ? ST_SHOWN : code_q;
	assign element = cmd.show ? rd_data_q : '0;
	assign last    = cmd.show ? sts.at_rear : 1'b1;

endmodule

>>> design/circular_deque_engine.sv
`timescale 1ns / 1ps
// Circular deque engine: double-ended queue in a circular slot store.
// Depends on cde_pkg, cde_ctrl and cde_datapath.
//
// Usage:
//  - Input channel (in_valid/in_ready, operation, value): one transaction
//    is one operation: push front, push rear, pop front, pop rear, display.
//  - Output channel (out_valid/out_ready, status, element, last): a push
//    into a full deque, a pop from an empty deque or one that empties it,
//    a display of an empty deque and an unknown code each give a single
//    status transaction with last set. Every other operation walks the
//    contents front to rear, one element per transaction, last on rear.
//  - Timing: in_ready is high only while idle. A decide state follows the
//    input transaction; the first result is valid from the next cycle.
//    Further elements follow one per cycle while out_ready is high. The
//    walk is paced by the store's one registered read port.
//  - A stalled receiver simply holds the current result; the walk resumes
//    when out_ready returns.
//  - cfg_wr_en/cfg_wr_data write the capacity (0 acts as 1, values above
//    the store depth act as the depth) and empty the deque. Write only
//    while idle.
//  - Reset (arst_n low) empties the deque and sets capacity to 16. Slot
//    contents are not cleared; only written slots are ever shown.
module circular_deque_engine import cde_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [2:0]               operation,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               status,
	output logic signed [DATA_W-1:0] element,
	output logic                     last,
	input  logic                     cfg_wr_en,
	input  logic [CAP_W-1:0]         cfg_wr_data
);

	cde_cmd_t cmd;
	cde_sts_t sts;

	// Sequencer: owns both handshakes.
	cde_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Store, indices, capacity and result fields.
	cde_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.operation   (operation),
		.value       (value),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.sts         (sts),
		.status      (status),
		.element     (element),
		.last        (last)
	);

	// Never take an item while a result is on offer.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a result is pending");

	// An accepted item is decided before any result appears.
	a_decide_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid)
		else $error("result valid right after acceptance");

	// Delivering the final result returns the block to idle.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> in_ready)
		else $error("not idle after final result");

	// Status reports are always single, final results.
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_SHOWN) |-> last)
		else $error("status result without last");

endmodule
